FILE: design/cdd_pkg.sv
// ----------------------------------------------------------------------------
// Central difference derivative: shared definitions
// Types and fixed constants used by the derivative top level and its serial
// slope unit.
// ----------------------------------------------------------------------------
package cdd_pkg;

   // Result and divisor formats do not vary with the sample width.
   localparam int SLOPE_WIDTH    = 32;
   localparam int NORM_WIDTH     = 32;
   localparam int NORM_FRAC_BITS = 16;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   // Quotient bits developed by the serial divider. Anything at or above
   // bit 33 is caught by one compare before the first step.
   localparam int QUOT_BITS = 33;

   localparam logic [SLOPE_WIDTH-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
   localparam logic [SLOPE_WIDTH-1:0] SLOPE_MIN = 32'h8000_0000;

   localparam logic [NORM_WIDTH-1:0] NORM_FACTOR_ONE = 32'h0001_0000;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SATURATED = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SHORT     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMALIZE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORM_FACTOR = 2'd2;

   // Status of the slope unit as seen by the controller.
   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic                   saturated;
      logic [SLOPE_WIDTH-1:0] slope;
   } slope_result_type;

endpackage

FILE: design/central_difference_derivative_unit.sv
// ----------------------------------------------------------------------------
// Central difference derivative unit
// Streaming slope estimator over records of (x, y) sample points.
// ----------------------------------------------------------------------------
// The block takes one sample transfer at a time and keeps the two previous
// points of the current record. Each interior point yields the central slope
// (y[i+1]-y[i-1])/(x[i+1]-x[i-1]) tagged with that point's own x; with
// edge_mode set, the first and last points of a record also get one-sided
// slopes. Slopes are signed fixed point with FRACTION_BITS fraction bits,
// rounded half away from zero, optionally divided by norm_factor (Q16.16),
// and saturated with status 1; a zero x step also saturates with status 1.
// A record of a single point returns one result with status 2. An input
// transfer is taken only when the controller is idle, so a new sample is not
// taken before the controller is through with the last one. Each slope goes
// through one shared serial unit: a 33-step radix-2 divider, preceded when
// normalizing by a shift-add multiplication that scales the x step by
// norm_factor. A zero x step or a quotient beyond the divider's reach
// finishes without running the divider. A two-point record in edge mode
// reuses its one slope for its second result, and an item yields two slopes
// only at a record end in edge mode. A full output register can hold up a
// result, but a waiting result in the output register does not hold off the
// next input transfer.
// ----------------------------------------------------------------------------
module central_difference_derivative_unit
   import cdd_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [NORM_WIDTH-1:0]          csr_write_data,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_y,
   input  logic                           req_end_of_record,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_point_x,
   output logic signed [SLOPE_WIDTH-1:0]  rsp_slope,
   output logic [STATUS_WIDTH-1:0]        rsp_status,
   output logic                           rsp_last_result
);

   localparam int DW = SAMPLE_WIDTH + 1;

   // Number of points of the current record held in the history.
   localparam logic [1:0] PS_NONE = 2'd0;
   localparam logic [1:0] PS_ONE  = 2'd1;
   localparam logic [1:0] PS_TWO  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_WAIT   = 5'b00100,
      ST_PUSH   = 5'b01000,
      ST_FINISH = 5'b10000
   } ctrl_state_type;

   // Configuration registers.
   logic                    edge_mode_ff;
   logic                    normalize_ff;
   logic [NORM_WIDTH-1:0]   norm_factor_ff;

   // Controller state.
   ctrl_state_type          state_ff, state_in;
   logic                    phase_ff, phase_in;
   logic [1:0]              ps_ff, ps_in;

   // Point history and the item being worked on.
   logic [SAMPLE_WIDTH-1:0] older_x_ff, older_y_ff;
   logic [SAMPLE_WIDTH-1:0] newer_x_ff, newer_y_ff;
   logic [SAMPLE_WIDTH-1:0] item_x_ff, item_y_ff;
   logic                    item_eor_ff;

   // Last slope from the serial unit, kept for reuse on a two-point record.
   logic [SLOPE_WIDTH-1:0]  res_slope_ff;
   logic                    res_sat_ff;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_point_x_ff;
   logic [SLOPE_WIDTH-1:0]  rsp_slope_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic                    rsp_last_ff;

   logic                    req_accept;
   logic                    slot_free;
   logic                    out_load;
   logic                    unit_start;
   logic                    hist_update;
   logic [SAMPLE_WIDTH-1:0] base_x, base_y;
   logic [DW-1:0]           delta_x, delta_y;
   logic [SAMPLE_WIDTH-1:0] out_x;
   logic [SLOPE_WIDTH-1:0]  out_slope;
   logic [STATUS_WIDTH-1:0] out_status;
   logic                    out_last;
   slope_result_type        unit_result;

   // ------------------------------------------------------------------------
   // Configuration writes. Indexes beyond the register list are dropped.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_mode_ff   <= 1'b1;
         normalize_ff   <= 1'b0;
         norm_factor_ff <= NORM_FACTOR_ONE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EDGE_MODE:   edge_mode_ff   <= csr_write_data[0];
            CSR_NORMALIZE:   normalize_ff   <= csr_write_data[0];
            CSR_NORM_FACTOR: norm_factor_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshakes. A result leaves the output register on a transfer, and a
   // new one may be loaded in that same cycle.
   // ------------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // The first slope of an item with two points of history spans the older
   // point; every other slope spans the newer one.
   assign base_x  = (ps_ff == PS_TWO && !phase_ff) ? older_x_ff : newer_x_ff;
   assign base_y  = (ps_ff == PS_TWO && !phase_ff) ? older_y_ff : newer_y_ff;
   assign delta_x = {item_x_ff[SAMPLE_WIDTH-1], item_x_ff} - {base_x[SAMPLE_WIDTH-1], base_x};
   assign delta_y = {item_y_ff[SAMPLE_WIDTH-1], item_y_ff} - {base_y[SAMPLE_WIDTH-1], base_y};

   // Fields of the result about to be loaded. The first result of an item
   // with history belongs to the newer point; all others to the item itself.
   always_comb begin
      out_x = (!phase_ff && ps_ff != PS_NONE) ? newer_x_ff : item_x_ff;
      if (ps_ff == PS_NONE) begin
         out_slope  = '0;
         out_status = STATUS_SHORT;
         out_last   = 1'b1;
      end else begin
         out_slope  = res_slope_ff;
         out_status = res_sat_ff ? STATUS_SATURATED : STATUS_OK;
         out_last   = phase_ff || (ps_ff == PS_TWO && item_eor_ff && !edge_mode_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Controller. Each accepted item walks through up to two result phases;
   // each phase either starts the slope unit, reuses the last slope, builds
   // the short-record result, or ends the item.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      ps_in       = ps_ff;
      unit_start  = 1'b0;
      out_load    = 1'b0;
      hist_update = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               phase_in = 1'b0;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            case (ps_ff)
               PS_NONE: begin
                  state_in = (item_eor_ff && !phase_ff) ? ST_PUSH : ST_FINISH;
               end
               PS_ONE: begin
                  if (!edge_mode_ff) begin
                     state_in = ST_FINISH;
                  end else if (!phase_ff) begin
                     unit_start = 1'b1;
                     state_in   = ST_WAIT;
                  end else begin
                     // Both edge results of a two-point record share a slope.
                     state_in = item_eor_ff ? ST_PUSH : ST_FINISH;
                  end
               end
               default: begin
                  if (!phase_ff || (item_eor_ff && edge_mode_ff)) begin
                     unit_start = 1'b1;
                     state_in   = ST_WAIT;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            endcase
         end

         ST_WAIT: begin
            if (unit_result.done) begin
               state_in = ST_PUSH;
            end
         end

         ST_PUSH: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (phase_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  phase_in = 1'b1;
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_FINISH: begin
            hist_update = 1'b1;
            state_in    = ST_IDLE;
            if (ps_ff == PS_NONE) begin
               ps_in = item_eor_ff ? PS_NONE : PS_ONE;
            end else begin
               ps_in = item_eor_ff ? PS_NONE : PS_TWO;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         ps_ff    <= PS_NONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ps_ff    <= ps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_x_ff   <= req_sample_x;
         item_y_ff   <= req_sample_y;
         item_eor_ff <= req_end_of_record;
      end
   end

   // History moves at the end of an item. A lone point that closes a record
   // leaves it untouched; the first point of a record only fills the newer
   // slot.
   always_ff @(posedge clock) begin
      if (hist_update) begin
         if (ps_ff == PS_NONE) begin
            if (!item_eor_ff) begin
               newer_x_ff <= item_x_ff;
               newer_y_ff <= item_y_ff;
            end
         end else begin
            older_x_ff <= newer_x_ff;
            older_y_ff <= newer_y_ff;
            newer_x_ff <= item_x_ff;
            newer_y_ff <= item_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (unit_result.done) begin
         res_slope_ff <= unit_result.slope;
         res_sat_ff   <= unit_result.saturated;
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!slot_free) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_point_x_ff <= out_x;
         rsp_slope_ff   <= out_slope;
         rsp_status_ff  <= out_status;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_point_x_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Serial slope unit.
   // ------------------------------------------------------------------------
   cdd_slope_unit #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_slope (
      .clock       (clock),
      .reset       (reset),
      .start       (unit_start),
      .delta_x     (delta_x),
      .delta_y     (delta_y),
      .normalize   (normalize_ff),
      .norm_factor (norm_factor_ff),
      .result      (unit_result)
   );

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The slope unit is started only when it has finished the previous slope.
   assert property (@(posedge clock) disable iff (reset)
      unit_start |-> !unit_result.busy)
      else $error("slope unit started while busy");

   // A finished slope arrives only while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      unit_result.done |-> (state_ff == ST_WAIT))
      else $error("slope unit finished outside the wait state");

   // The point count saturates at two.
   assert property (@(posedge clock) disable iff (reset)
      ps_ff != 2'd3)
      else $error("point count out of range");

   // A short-record result always closes the record with a zero slope.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_SHORT) |-> (rsp_last_result && rsp_slope == '0))
      else $error("short-record result malformed");

endmodule

FILE: design/cdd_slope_unit.sv
// ----------------------------------------------------------------------------
// Central difference derivative: serial slope unit
// Turns one (dx, dy) pair into a rounded, saturated fixed-point slope with a
// shift-add multiplier for the divisor and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module cdd_slope_unit
   import cdd_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SAMPLE_WIDTH:0] delta_x,
   input  logic signed [SAMPLE_WIDTH:0] delta_y,
   input  logic                    normalize,
   input  logic [NORM_WIDTH-1:0]   norm_factor,
   output slope_result_type        result
);

   localparam int DW          = SAMPLE_WIDTH + 1;
   localparam int DEN_W       = DW + NORM_WIDTH;
   localparam int NHW         = DW + FRACTION_BITS + NORM_FRAC_BITS;
   localparam int NW          = NHW + QUOT_BITS;
   localparam int CW          = (NHW > DEN_W) ? NHW : DEN_W;
   localparam int Q1W         = QUOT_BITS + 1;
   localparam int CNT_W       = $clog2(QUOT_BITS);
   localparam int SHIFT_PLAIN = FRACTION_BITS;
   localparam int SHIFT_NORM  = FRACTION_BITS + NORM_FRAC_BITS;

   typedef enum logic [6:0] {
      U_IDLE  = 7'b0000001,
      U_PREP  = 7'b0000010,
      U_MUL   = 7'b0000100,
      U_LOAD  = 7'b0001000,
      U_DIV   = 7'b0010000,
      U_ROUND = 7'b0100000,
      U_SIGN  = 7'b1000000
   } unit_state_type;

   unit_state_type            state_ff, state_in;
   logic [DW-1:0]             dx_ff, dx_in;
   logic [DW-1:0]             dy_ff, dy_in;
   logic                      norm_ff, norm_in;
   logic [NORM_WIDTH-1:0]     nf_ff, nf_in;
   logic [DW-1:0]             mag_x_ff, mag_x_in;
   logic [DW-1:0]             mag_y_ff, mag_y_in;
   logic                      neg_ff, neg_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [QUOT_BITS-1:0]      low_ff, low_in;
   logic [Q1W-1:0]            quot_ff, quot_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      done_ff, done_in;
   logic                      sat_ff, sat_in;
   logic [SLOPE_WIDTH-1:0]    slope_ff, slope_in;

   logic [DW-1:0]             mag_x;
   logic [DW-1:0]             mag_y;
   logic [NW-1:0]             num_full;
   logic [NHW-1:0]            num_high;
   logic [DEN_W:0]            trial;
   logic                      trial_fits;
   logic                      round_up;
   logic [Q1W-1:0]            limit;

   always_comb begin
      mag_x      = dx_ff[DW-1] ? $unsigned(-$signed(dx_ff)) : dx_ff;
      mag_y      = dy_ff[DW-1] ? $unsigned(-$signed(dy_ff)) : dy_ff;
      num_full   = norm_ff ? (NW'(mag_y_ff) << SHIFT_NORM) : (NW'(mag_y_ff) << SHIFT_PLAIN);
      num_high   = num_full[NW-1:QUOT_BITS];
      trial      = {rem_ff, low_ff[QUOT_BITS-1]};
      trial_fits = trial >= {1'b0, den_ff};
      round_up   = {rem_ff, 1'b0} >= {1'b0, den_ff};
      limit      = neg_ff ? Q1W'(SLOPE_MIN) : Q1W'(SLOPE_MAX);
   end

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      norm_in  = norm_ff;
      nf_in    = nf_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      sat_in   = sat_ff;
      slope_in = slope_ff;

      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               dx_in    = delta_x;
               dy_in    = delta_y;
               norm_in  = normalize;
               nf_in    = norm_factor;
               state_in = U_PREP;
            end
         end

         U_PREP: begin
            mag_x_in = mag_x;
            mag_y_in = mag_y;
            neg_in   = dx_ff[DW-1] ^ dy_ff[DW-1];
            count_in = '0;
            if (mag_x == '0 || (norm_ff && nf_ff == '0)) begin
               // A zero step saturates toward the sign of dy.
               sat_in   = 1'b1;
               done_in  = 1'b1;
               state_in = U_IDLE;
               if (dy_ff == '0) begin
                  slope_in = '0;
               end else begin
                  slope_in = dy_ff[DW-1] ? SLOPE_MIN : SLOPE_MAX;
               end
            end else if (norm_ff) begin
               den_in   = '0;
               state_in = U_MUL;
            end else begin
               den_in   = DEN_W'(mag_x);
               state_in = U_LOAD;
            end
         end

         U_MUL: begin
            // One norm factor bit per cycle, most significant first.
            den_in   = {den_ff[DEN_W-2:0], 1'b0}
                     + (nf_ff[NORM_WIDTH-1] ? DEN_W'(mag_x_ff) : DEN_W'(0));
            nf_in    = {nf_ff[NORM_WIDTH-2:0], 1'b0};
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(NORM_WIDTH - 1)) begin
               state_in = U_LOAD;
            end
         end

         U_LOAD: begin
            count_in = '0;
            quot_in  = '0;
            low_in   = num_full[QUOT_BITS-1:0];
            if (CW'(num_high) >= CW'(den_ff)) begin
               // Quotient has bits at or above the divider's reach.
               sat_in   = 1'b1;
               slope_in = neg_ff ? SLOPE_MIN : SLOPE_MAX;
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               rem_in   = DEN_W'(num_high);
               state_in = U_DIV;
            end
         end

         U_DIV: begin
            rem_in   = trial_fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quot_in  = {quot_ff[Q1W-2:0], trial_fits};
            low_in   = {low_ff[QUOT_BITS-2:0], 1'b0};
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(QUOT_BITS - 1)) begin
               state_in = U_ROUND;
            end
         end

         U_ROUND: begin
            // Round half away from zero on the magnitude.
            quot_in  = quot_ff + Q1W'(round_up);
            state_in = U_SIGN;
         end

         U_SIGN: begin
            done_in  = 1'b1;
            state_in = U_IDLE;
            if (quot_ff > limit) begin
               sat_in   = 1'b1;
               slope_in = neg_ff ? SLOPE_MIN : SLOPE_MAX;
            end else begin
               sat_in   = 1'b0;
               slope_in = neg_ff ? (SLOPE_WIDTH'(0) - quot_ff[SLOPE_WIDTH-1:0])
                                 : quot_ff[SLOPE_WIDTH-1:0];
            end
         end

         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      norm_ff  <= norm_in;
      nf_ff    <= nf_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      sat_ff   <= sat_in;
      slope_ff <= slope_in;
   end

   assign result.busy      = (state_ff != U_IDLE);
   assign result.done      = done_ff;
   assign result.saturated = sat_ff;
   assign result.slope     = slope_ff;

endmodule

FILE: dv/central_difference_derivative_unit_test.sv
// ----------------------------------------------------------------------------
// Central difference derivative unit: self-checking testbench
// Sends records of (x, y) sample points through the unit under a series of
// register settings and idle/stall patterns. Each slope is predicted from the
// sample stream and compared field by field with what the unit returns.
// ----------------------------------------------------------------------------
module central_difference_derivative_unit_test;
   import cdd_pkg::*;

   localparam int SAMPLE_WIDTH   = 32;
   localparam int FRACTION_BITS  = 16;
   localparam int RESET_CYCLES   = 6;
   // Covers the worst item, two normalized slopes, and also an item that
   // yields nothing but is still being worked on.
   localparam int SETTLE_CYCLES  = 300;
   // Cycles without any transfer or register write before the run is
   // declared hung.
   localparam int WATCHDOG_LIMIT = 5000;
   // Index 3 maps to no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum int {REC_NOISE, REC_RAMP, REC_STEPPY} record_style_type;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] x;
      logic signed [SAMPLE_WIDTH-1:0] y;
      logic                           eor;
   } sample_point_type;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] point_x;
      logic [SLOPE_WIDTH-1:0]         slope;
      logic [STATUS_WIDTH-1:0]        status;
      logic                           last_result;
   } expected_result_type;

   // Every input is driven to a known value from time zero.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [NORM_WIDTH-1:0]          csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_x = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_y = '0;
   logic                           req_end_of_record = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_point_x;
   logic signed [SLOPE_WIDTH-1:0]  rsp_slope;
   logic [STATUS_WIDTH-1:0]        rsp_status;
   logic                           rsp_last_result;

   // Points waiting to be sent, and slopes waiting to be returned.
   sample_point_type    pending_points[$];
   expected_result_type expected_slopes[$];

   // Our own copy of the register file, kept at reset values until written.
   logic                  cfg_edge_mode   = 1'b1;
   logic                  cfg_normalize   = 1'b0;
   logic [NORM_WIDTH-1:0] cfg_norm_factor = NORM_FACTOR_ONE;

   // The two previous points of the open record; near is the latest one.
   logic signed [SAMPLE_WIDTH-1:0] far_x  = '0;
   logic signed [SAMPLE_WIDTH-1:0] far_y  = '0;
   logic signed [SAMPLE_WIDTH-1:0] near_x = '0;
   logic signed [SAMPLE_WIDTH-1:0] near_y = '0;
   int unsigned                    points_held = 0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit point_taken        = 1'b0;
   int quiet_cycles       = 0;
   int error_count        = 0;
   int points_accepted    = 0;
   int records_closed     = 0;
   int results_checked    = 0;
   int saturated_seen     = 0;
   int short_seen         = 0;
   int settings_applied   = 0;

   central_difference_derivative_unit #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_x      (req_sample_x),
      .req_sample_y      (req_sample_y),
      .req_end_of_record (req_end_of_record),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_slope         (rsp_slope),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Slope dy / dx in signed fixed point, divided by the norm factor when
   // normalizing. The quotient is exact on magnitudes and then rounded to
   // nearest with ties away from zero. Anything outside 32-bit signed range
   // saturates. A zero x step, or a zero factor while normalizing, saturates
   // toward the sign of dy, or gives zero when dy is zero too.
   function automatic void fixed_slope(input longint dx, input longint dy,
                                       output logic [SLOPE_WIDTH-1:0] value,
                                       output logic [STATUS_WIDTH-1:0] code);
      logic [127:0] numerator, denominator, quotient, remainder;
      logic [63:0]  mag_dx, mag_dy, divisor, limit;
      logic         negative;
      negative = (dx < 0) != (dy < 0);
      mag_dx   = (dx < 0) ? -dx : dx;
      mag_dy   = (dy < 0) ? -dy : dy;
      divisor  = cfg_normalize ? {32'b0, cfg_norm_factor} : 64'd1;
      if (mag_dx == 0 || divisor == 0) begin
         code = STATUS_SATURATED;
         if (mag_dy == 0)
            value = '0;
         else
            value = (dy < 0) ? SLOPE_MIN : SLOPE_MAX;
      end else begin
         numerator = {64'b0, mag_dy} << (cfg_normalize ? FRACTION_BITS + NORM_FRAC_BITS
                                                        : FRACTION_BITS);
         denominator = {64'b0, mag_dx} * {64'b0, divisor};
         quotient    = numerator / denominator;
         remainder   = numerator % denominator;
         if ((remainder << 1) >= denominator)
            quotient = quotient + 1;
         limit = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (quotient > limit) begin
            code  = STATUS_SATURATED;
            value = negative ? SLOPE_MIN : SLOPE_MAX;
         end else begin
            code  = STATUS_OK;
            value = negative ? -quotient[SLOPE_WIDTH-1:0] : quotient[SLOPE_WIDTH-1:0];
         end
      end
   endfunction

   // Works out the results one accepted point causes and moves the window of
   // held points along. The second point of a record gives the forward edge
   // slope for the first point only in edge mode; later points give the
   // central slope of the previous point, and a record end in edge mode adds
   // the backward slope of the last point.
   task automatic derive_slopes(input logic signed [SAMPLE_WIDTH-1:0] x,
                                input logic signed [SAMPLE_WIDTH-1:0] y,
                                input logic eor);
      logic [SLOPE_WIDTH-1:0]  value;
      logic [STATUS_WIDTH-1:0] code;
      if (points_held == 0) begin
         if (eor) begin
            // A record of one point has nothing to difference against.
            expected_slopes.push_back('{x, '0, STATUS_SHORT, 1'b1});
         end else begin
            near_x      = x;
            near_y      = y;
            points_held = 1;
         end
      end else begin
         if (points_held == 1) begin
            if (cfg_edge_mode) begin
               fixed_slope(longint'(x) - longint'(near_x), longint'(y) - longint'(near_y),
                           value, code);
               expected_slopes.push_back('{near_x, value, code, 1'b0});
               if (eor)
                  expected_slopes.push_back('{x, value, code, 1'b1});
            end
         end else begin
            fixed_slope(longint'(x) - longint'(far_x), longint'(y) - longint'(far_y),
                        value, code);
            expected_slopes.push_back('{near_x, value, code, eor && !cfg_edge_mode});
            if (eor && cfg_edge_mode) begin
               fixed_slope(longint'(x) - longint'(near_x), longint'(y) - longint'(near_y),
                           value, code);
               expected_slopes.push_back('{x, value, code, 1'b1});
            end
         end
         far_x       = near_x;
         far_y       = near_y;
         near_x      = x;
         near_y      = y;
         points_held = eor ? 0 : 2;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
   endtask

   // Register writes take effect in our copy at the same time, which is safe
   // because writes only happen while the unit is idle.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [NORM_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_EDGE_MODE:   cfg_edge_mode   = data[0];
         CSR_NORMALIZE:   cfg_normalize   = data[0];
         CSR_NORM_FACTOR: cfg_norm_factor = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The unit may still be chewing on a point that yields no result, so a
   // fixed pause precedes every group of writes. The one-bit registers get
   // random upper bits to show that only bit zero counts.
   task automatic configure(input logic edge_on, input logic norm_on,
                            input logic [NORM_WIDTH-1:0] factor);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_EDGE_MODE, {31'($urandom), edge_on});
      write_csr(CSR_NORMALIZE, {31'($urandom), norm_on});
      write_csr(CSR_NORM_FACTOR, factor);
      settings_applied++;
   endtask

   task automatic wait_for_results();
      while (pending_points.size() != 0 || req_valid || expected_slopes.size() != 0)
         @(posedge clock);
   endtask

   task automatic point(input logic signed [SAMPLE_WIDTH-1:0] x,
                        input logic signed [SAMPLE_WIDTH-1:0] y, input logic eor);
      pending_points.push_back('{x, y, eor});
   endtask

   // Ramps are the well-formed case: rising x with varied step sizes and a
   // y that wanders by random amounts. Steppy records hit repeated x values,
   // and noise records take any value at all, wrapping included.
   task automatic queue_record(input int len, input record_style_type style);
      int x, y, span;
      x = $urandom;
      y = $urandom;
      for (int i = 0; i < len; i++) begin
         case (style)
            REC_NOISE: begin
               x = $urandom;
               y = $urandom;
            end
            REC_RAMP: begin
               if (i > 0) begin
                  x    = x + int'($urandom_range(1, 1 << $urandom_range(0, 20)));
                  span = 1 << $urandom_range(0, 24);
                  y    = y + int'($urandom_range(0, 2 * span)) - span;
               end
            end
            default: begin
               x = x + int'($urandom_range(0, 2));
               y = y + int'($urandom_range(0, 64)) - 32;
            end
         endcase
         point(x, y, i == len - 1);
      end
   endtask

   // Mostly records of a handful of points, some one- or two-point records
   // and a few long ones.
   task automatic queue_random(input int count);
      int total, len, pick;
      record_style_type style;
      total = 0;
      while (total < count) begin
         pick = $urandom_range(99);
         if (pick < 10)
            len = $urandom_range(1, 2);
         else if (pick < 13)
            len = $urandom_range(20, 40);
         else
            len = $urandom_range(3, 10);
         pick  = $urandom_range(99);
         style = (pick < 60) ? REC_RAMP : (pick < 80) ? REC_STEPPY : REC_NOISE;
         queue_record(len, style);
         total += len;
      end
   endtask

   // Driver: a new point goes out at the falling edge only once the previous
   // one has been transferred; a stalled point is held as it is. Whether the
   // sender idles is decided without looking at the stall.
   always @(negedge clock) begin : drive_points
      sample_point_type next_point;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !point_taken) begin
         // Still waiting for the transfer; keep the point on the wires.
      end else if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
         next_point        = pending_points.pop_front();
         req_valid         <= 1'b1;
         req_sample_x      <= next_point.x;
         req_sample_y      <= next_point.y;
         req_end_of_record <= next_point.eor;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : drive_stall
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   // Monitor: at the rising edge, an accepted point feeds the predictor and
   // an accepted result is checked against the oldest expected slope. The
   // prediction runs first so that the queue is always up to date.
   always @(posedge clock) begin : check_results
      expected_result_type want;
      point_taken = !reset && req_valid && !req_stall;
      if (point_taken) begin
         derive_slopes(req_sample_x, req_sample_y, req_end_of_record);
         points_accepted++;
         if (req_end_of_record)
            records_closed++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (rsp_status == STATUS_SATURATED)
            saturated_seen++;
         if (rsp_status == STATUS_SHORT)
            short_seen++;
         if (expected_slopes.size() == 0) begin
            report_mismatch("result with no slope pending", rsp_point_x, '0);
         end else begin
            want = expected_slopes.pop_front();
            if (rsp_point_x !== want.point_x)
               report_mismatch("point_x", rsp_point_x, want.point_x);
            if (rsp_slope !== want.slope)
               report_mismatch("slope", rsp_slope, want.slope);
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_last_result !== want.last_result)
               report_mismatch("last_result", 32'(rsp_last_result), 32'(want.last_result));
         end
      end
   end

   // The watchdog counts cycles in which nothing at all is transferred.
   always @(posedge clock) begin : count_quiet
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("unit hung: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("central_difference_derivative_unit_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edge mode at unit scale, no idling. Directed records first: a single
      // point, the widest possible x and y span, slopes that overflow, zero
      // x steps with negative and zero dy, and half-way ties.
      configure(1'b1, 1'b0, NORM_FACTOR_ONE);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      point(5, 7, 1'b1);
      point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      point(0, 32'sh8000_0000, 1'b0);
      point(1, 32'sh7FFF_FFFF, 1'b0);
      point(1, 0, 1'b0);
      point(1, 0, 1'b0);
      point(3, -5, 1'b1);
      point(0, 0, 1'b0);
      point(131072, 1, 1'b0);
      point(262144, 0, 1'b0);
      point(393216, -1, 1'b0);
      point(524288, 0, 1'b1);
      point(100, 50, 1'b0);
      point(100, 50, 1'b1);
      point(10, 100, 1'b0);
      point(10, -100, 1'b1);
      queue_random(150);
      wait_for_results();

      // Central points only, sender idling half the time. A two-point record
      // must give nothing; a single point still reports a short record.
      configure(1'b0, 1'b0, $urandom);
      sender_idle_pct    = 50;
      receiver_stall_pct = 0;
      point(7, 9, 1'b1);
      point(1, 2, 1'b0);
      point(3, 4, 1'b1);
      point(0, 0, 1'b0);
      point(1, 1, 1'b0);
      point(2, 4, 1'b1);
      queue_random(250);
      wait_for_results();

      // Normalizing by one, receiver stalling half the time. Halfway through
      // the sender holds off until every slope so far has come back.
      configure(1'b1, 1'b1, NORM_FACTOR_ONE);
      sender_idle_pct    = 0;
      receiver_stall_pct = 50;
      queue_random(125);
      wait_for_results();
      queue_random(125);
      wait_for_results();

      // Smallest nonzero factor, both sides idling.
      configure(1'b1, 1'b1, 32'd1);
      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      queue_random(200);
      wait_for_results();

      // Largest factor, central only, no idling.
      configure(1'b0, 1'b1, 32'hFFFF_FFFF);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      queue_random(200);
      wait_for_results();

      // A zero factor while normalizing saturates like a zero x step. The
      // unmapped index is written here too and must leave the factor alone.
      configure(1'b1, 1'b1, 32'd0);
      write_csr(CSR_UNMAPPED, $urandom | 32'd1);
      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      point(0, 0, 1'b0);
      point(1, 10, 1'b0);
      point(2, 0, 1'b1);
      point(-3, 4, 1'b1);
      queue_random(60);
      wait_for_results();

      // Random factors of moderate size with everything else on.
      configure(1'b1, 1'b1, $urandom_range(1 << 12, 1 << 20));
      queue_random(350);
      wait_for_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d sample transfers in %0d records under %0d register settings",
               points_accepted, records_closed, settings_applied);
      $display("checked %0d results, %0d saturated and %0d short records, %0d mismatches",
               results_checked, saturated_seen, short_seen, error_count);
      if (error_count == 0)
         $display("central_difference_derivative_unit_test: done, clean");
      else
         $display("central_difference_derivative_unit_test: done, errors");
      $finish;
   end

endmodule
